FILE: sv/asseq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asseq_pkg
// Shared types and constants of the addressable step sequencer index block.
// ----------------------------------------------------------------------------
package asseq_pkg;

   // sequence geometry (SEQ_LEN is a power of two: final wrap is a bit mask)
   localparam int SEQ_LEN  = 8;
   localparam int SEQ_LOG2 = 3;
   localparam int STEP_W   = 3;
   localparam int CHANNELS = 16;
   localparam int CH_W     = 4;

   // knob fields (steps_in_use, select_base)
   localparam int CNT_W = 4;
   localparam logic [CNT_W-1:0] SEQ_LEN_C = CNT_W'(SEQ_LEN);

   // select offset and voltage scaling
   localparam int OFF_W    = 6;
   localparam int CV_W     = 16;
   localparam int CV_FRAC  = 15;
   localparam int POS_W    = 21;
   localparam int POS_PAD  = POS_W - CNT_W - CV_FRAC;
   localparam int ROUND_BIAS = (2 ** CV_FRAC) - 1;
   localparam logic signed [CV_W-1:0] CV_MAX = 16'sd32735;
   localparam logic signed [CV_W-1:0] CV_MIN = -16'sd32735;

   // shared remainder unit
   localparam int DIV_W  = 5;
   localparam int REM_W  = 4;
   localparam int ITER_W = 3;
   localparam logic [ITER_W-1:0] DIV_LAST = ITER_W'(DIV_W - 1);

   // holdoff
   localparam int HOLD_W = 12;
   localparam logic [HOLD_W-1:0] HOLD_RESET = 12'd48;

   // ports
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;
   localparam int JUMP_W     = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_STEPS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FORWARD   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SEL_BASE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REV_NEG   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TRIG_SEL  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SEL_CLOCK = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_HOLDOFF   = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_STEP_DIV,
      ST_STEP_FIN,
      ST_SEL_DIV,
      ST_SEL_FIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;    // latch request beat
      logic eval;       // edges, holdoff, step sum, voltage select
      logic div_step;   // one remainder iteration
      logic step_take;  // step result, load select remainder
      logic sel_take;   // select result
      logic commit;     // write channel state, load output
   } ctrl_cmd_type;

   typedef struct packed {
      logic sel_div;    // trigger-mode select edge needs a remainder pass
      logic out_stall;  // output register held by the sink
   } ctrl_status_type;

endpackage

FILE: sv/asseq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asseq_ctrl
// Sequencer FSM: walks one tick request through evaluation, remainder passes
// and commit (a jump goes straight to commit), issuing commands to the datapath.
// ----------------------------------------------------------------------------
module asseq_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tuser,
   output logic                     req_tready,
   input  asseq_pkg::ctrl_status_type status,
   output asseq_pkg::ctrl_cmd_type  cmd
);
   import asseq_pkg::*;

   state_type         state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      iter_in  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = req_tuser ? ST_DONE : ST_EVAL;
            end
         end
         ST_EVAL: state_in = ST_STEP_DIV;
         ST_STEP_DIV: begin
            iter_in = iter_ff + 1'b1;
            if (iter_ff == DIV_LAST) begin
               state_in = ST_STEP_FIN;
               iter_in  = '0;
            end
         end
         ST_STEP_FIN: state_in = status.sel_div ? ST_SEL_DIV : ST_DONE;
         ST_SEL_DIV: begin
            iter_in = iter_ff + 1'b1;
            if (iter_ff == DIV_LAST) begin
               state_in = ST_SEL_FIN;
               iter_in  = '0;
            end
         end
         ST_SEL_FIN: state_in = ST_DONE;
         ST_DONE: begin
            if (!status.out_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_EVAL:     cmd.eval      = 1'b1;
         ST_STEP_DIV: cmd.div_step  = 1'b1;
         ST_STEP_FIN: cmd.step_take = 1'b1;
         ST_SEL_DIV:  cmd.div_step  = 1'b1;
         ST_SEL_FIN:  cmd.sel_take  = 1'b1;
         ST_DONE:     cmd.commit    = !status.out_stall;
         default:     cmd           = '0;
      endcase
   end

endmodule

FILE: sv/asseq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asseq_dp
// Datapath: control registers, per-channel state file, edge/holdoff logic,
// voltage select scaling, shared restoring remainder unit, output register.
// ----------------------------------------------------------------------------
module asseq_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  asseq_pkg::ctrl_cmd_type              cmd,
   output asseq_pkg::ctrl_status_type           status,
   input  logic                                 csr_valid,
   input  logic [asseq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [asseq_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic [asseq_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [asseq_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import asseq_pkg::*;

   // control registers
   logic [CNT_W-1:0]  steps_ff, base_ff;
   logic              fwd_ff, rev_ff, trig_ff, soc_ff;
   logic [HOLD_W-1:0] hold_ticks_ff;

   // request beat
   logic                   mode_ff, clk_lv_ff, neg_lv_ff, rst_lv_ff, sel_lv_ff;
   logic [CH_W-1:0]        chan_ff;
   logic signed [CV_W-1:0] cv_ff;
   logic [JUMP_W-1:0]      jump_ff;

   // per-channel state
   logic [STEP_W-1:0]       step_arr_ff [CHANNELS];
   logic signed [OFF_W-1:0] off_arr_ff  [CHANNELS];
   logic [HOLD_W-1:0]       hold_arr_ff [CHANNELS];
   logic [CHANNELS-1:0]     clk_prev_ff, neg_prev_ff, rst_prev_ff, sel_prev_ff;

   // working registers
   logic                    rst_ff, rst_in;
   logic                    sel_div_ff, sel_div_in;
   logic [STEP_W-1:0]       st_ff, st_in;
   logic signed [OFF_W-1:0] off_ff, off_in;

   // remainder unit
   logic [DIV_W-1:0] dvd_ff, dvd_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] dm_ff, dm_in;
   logic             dneg_ff, dneg_in;

   logic                  out_vld_ff, out_vld_in;
   logic [STEP_W-1:0]     out_ff, out_in;

   // combinational terms
   logic                    rst_edge, masked, clk_edge, neg_edge, sel_edge, up, dn;
   logic [HOLD_W-1:0]       hold_cur, hold_next;
   logic [CNT_W-1:0]        steps_eff, base_eff;
   logic signed [DIV_W-1:0] x_v;
   logic signed [CV_W-1:0]  cv_c;
   logic signed [POS_W-1:0] pos_v, pos_adj;
   logic signed [OFF_W-1:0] q_v, y_v, off_fin, sum_v;
   logic [DIV_W-1:0]        t_v;
   logic                    ge;

   always_comb begin
      rst_edge  = rst_lv_ff & ~rst_prev_ff[chan_ff];
      hold_cur  = rst_edge ? hold_ticks_ff : hold_arr_ff[chan_ff];
      masked    = (hold_cur != '0);
      hold_next = masked ? hold_cur - 1'b1 : hold_cur;
      clk_edge  = clk_lv_ff & ~clk_prev_ff[chan_ff] & ~masked;
      neg_edge  = neg_lv_ff & ~neg_prev_ff[chan_ff] & rev_ff & ~masked & ~clk_edge;
      sel_edge  = sel_lv_ff & ~sel_prev_ff[chan_ff];

      if (steps_ff == '0) begin
         steps_eff = CNT_W'(1);
      end else if (steps_ff > SEQ_LEN_C) begin
         steps_eff = SEQ_LEN_C;
      end else begin
         steps_eff = steps_ff;
      end
      base_eff = (base_ff >= SEQ_LEN_C) ? SEQ_LEN_C : base_ff;

      up  = (clk_edge & fwd_ff) | (neg_edge & ~fwd_ff);
      dn  = (clk_edge & ~fwd_ff) | (neg_edge & fwd_ff);
      x_v = $signed({2'b00, step_arr_ff[chan_ff]}) + (up ? 5'sd1 : 5'sd0)
            - (dn ? 5'sd1 : 5'sd0);

      // voltage select: base + cv*N/32768, truncated toward zero
      if (cv_ff > CV_MAX) begin
         cv_c = CV_MAX;
      end else if (cv_ff < CV_MIN) begin
         cv_c = CV_MIN;
      end else begin
         cv_c = cv_ff;
      end
      pos_v   = $signed({{POS_PAD{1'b0}}, base_eff, {CV_FRAC{1'b0}}})
                + (POS_W'(cv_c) <<< SEQ_LOG2);
      pos_adj = pos_v + (pos_v[POS_W-1] ? POS_W'(ROUND_BIAS) : '0);
      q_v     = pos_adj[CV_FRAC +: OFF_W];

      y_v = off_ff + 6'sd1;

      // restoring remainder iteration
      t_v = {rem_ff, dvd_ff[DIV_W-1]};
      ge  = (t_v >= {1'b0, dm_ff});

      off_fin = (trig_ff & rst_ff) ? '0 : off_ff;
      sum_v   = $signed({3'b000, st_ff}) + off_fin;
   end

   // working register next values
   always_comb begin
      rst_in     = rst_ff;
      sel_div_in = sel_div_ff;
      st_in      = st_ff;
      off_in     = off_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      dm_in      = dm_ff;
      dneg_in    = dneg_ff;
      if (cmd.eval) begin
         rst_in     = rst_edge;
         sel_div_in = trig_ff & sel_edge;
         if (!trig_ff && (!soc_ff || clk_edge)) begin
            off_in = q_v;
         end else begin
            off_in = off_arr_ff[chan_ff];
         end
         dvd_in  = x_v[DIV_W-1] ? DIV_W'(-x_v) : DIV_W'(x_v);
         rem_in  = '0;
         dm_in   = steps_eff;
         dneg_in = x_v[DIV_W-1];
      end
      if (cmd.div_step) begin
         rem_in = ge ? REM_W'(t_v - {1'b0, dm_ff}) : t_v[REM_W-1:0];
         dvd_in = dvd_ff << 1;
      end
      if (cmd.step_take) begin
         if (rst_ff) begin
            st_in = '0;
         end else if (dneg_ff && rem_ff != '0) begin
            st_in = STEP_W'(dm_ff - rem_ff);
         end else begin
            st_in = STEP_W'(rem_ff);
         end
         dvd_in  = y_v[OFF_W-1] ? DIV_W'(-y_v) : DIV_W'(y_v);
         rem_in  = '0;
         dm_in   = base_eff + 1'b1;
         dneg_in = y_v[OFF_W-1];
      end
      if (cmd.sel_take) begin
         off_in = dneg_ff ? -$signed({2'b00, rem_ff}) : $signed({2'b00, rem_ff});
      end
   end

   // output register
   always_comb begin
      out_vld_in = out_vld_ff & ~rsp_tready;
      out_in     = out_ff;
      if (cmd.commit) begin
         out_vld_in = 1'b1;
         out_in     = mode_ff ? STEP_W'(jump_ff % JUMP_W'(SEQ_LEN)) : sum_v[STEP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rst_ff     <= rst_in;
      sel_div_ff <= sel_div_in;
      st_ff      <= st_in;
      off_ff     <= off_in;
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      dm_ff      <= dm_in;
      dneg_ff    <= dneg_in;
      out_ff     <= out_in;
      if (cmd.capture) begin
         mode_ff   <= req_tuser;
         chan_ff   <= req_tdata[3:0];
         clk_lv_ff <= req_tdata[4];
         neg_lv_ff <= req_tdata[5];
         rst_lv_ff <= req_tdata[6];
         sel_lv_ff <= req_tdata[7];
         cv_ff     <= $signed(req_tdata[23:8]);
         jump_ff   <= req_tdata[31:24];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff      <= SEQ_LEN_C;
         fwd_ff        <= 1'b1;
         base_ff       <= '0;
         rev_ff        <= 1'b0;
         trig_ff       <= 1'b0;
         soc_ff        <= 1'b0;
         hold_ticks_ff <= HOLD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_STEPS:     steps_ff      <= csr_data[CNT_W-1:0];
            REG_FORWARD:   fwd_ff        <= csr_data[0];
            REG_SEL_BASE:  base_ff       <= csr_data[CNT_W-1:0];
            REG_REV_NEG:   rev_ff        <= csr_data[0];
            REG_TRIG_SEL:  trig_ff       <= csr_data[0];
            REG_SEL_CLOCK: soc_ff        <= csr_data[0];
            REG_HOLDOFF:   hold_ticks_ff <= csr_data[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         clk_prev_ff <= '0;
         neg_prev_ff <= '0;
         rst_prev_ff <= '0;
         sel_prev_ff <= '0;
         for (int k = 0; k < CHANNELS; k++) begin
            step_arr_ff[k] <= '0;
            off_arr_ff[k]  <= '0;
            hold_arr_ff[k] <= '0;
         end
      end else begin
         out_vld_ff <= out_vld_in;
         if (cmd.eval) begin
            clk_prev_ff[chan_ff] <= clk_lv_ff;
            neg_prev_ff[chan_ff] <= neg_lv_ff;
            rst_prev_ff[chan_ff] <= rst_lv_ff;
            hold_arr_ff[chan_ff] <= hold_next;
            if (trig_ff) begin
               sel_prev_ff[chan_ff] <= sel_lv_ff;
            end
         end
         if (cmd.commit) begin
            step_arr_ff[chan_ff] <= mode_ff ? STEP_W'(jump_ff % JUMP_W'(SEQ_LEN)) : st_ff;
            if (!mode_ff) begin
               off_arr_ff[chan_ff] <= off_fin;
            end
         end
      end
   end

   assign status.sel_div   = sel_div_ff;
   assign status.out_stall = out_vld_ff & ~rsp_tready;
   assign rsp_tvalid       = out_vld_ff;
   assign rsp_tdata        = {{(RSP_DATA_W - STEP_W){1'b0}}, out_ff};

endmodule

FILE: sv/addressable_step_sequencer_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressable_step_sequencer_index
// Per-channel step address logic of an addressable step sequencer.
// ----------------------------------------------------------------------------
// One request beat is one sample tick (or a jump) for one of 16 channels; one
// response beat carries the step to play. A tick is evaluated, then passes
// through the step wrap and, with a trigger-mode select edge, the select wrap
// before its result is loaded; a jump loads its result straight after
// accept. The block holds each beat until its result is loaded. A sink
// that stalls an earlier result adds its stall to the final load.
// Both wraps run on the shared restoring remainder unit, which spends five
// iterations (one bit a cycle) on the step wrap and five more on the select
// wrap. One beat is in work at a time; the output register lets the next
// request be accepted while a result waits for the sink. Configuration
// writes are taken every cycle (csr_ready is tied high) and must only be
// issued while no request is in work. Channel state (step, select offset,
// previous comparator levels, holdoff count) lives in flip-flops and is
// cleared by reset.
// ----------------------------------------------------------------------------
module addressable_step_sequencer_index (
   input  logic                                clock,
   input  logic                                reset,
   // request: tdata = channel[3:0], clock_high[4], clock_negative[5],
   //          reset_high[6], select_high[7], select_cv[23:8], jump_step[31:24]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [asseq_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                                req_tuser,   // mode[0]: 1 = jump
   // response: tdata = selected_step[2:0], zero above
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [asseq_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [asseq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [asseq_pkg::CSR_DATA_W-1:0]    csr_data
);
   import asseq_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   assign csr_ready = 1'b1;

   asseq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   asseq_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: sv/asseq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asseq_checker
// Port-level checks of the step sequencer index block, bound to the top.
// ----------------------------------------------------------------------------
module asseq_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [asseq_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import asseq_pkg::*;

   logic [1:0] pend_ff, pend_in;

   // beats accepted but not yet delivered
   always_comb begin
      pend_in = pend_ff + 2'((req_tvalid & req_tready))
                - 2'((rsp_tvalid & rsp_tready));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:STEP_W] == '0)
      else $error("response padding not zero");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in work");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pend_ff != 2'd0)
      else $error("response without a pending request");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more than two beats pending");

endmodule

bind addressable_step_sequencer_index asseq_checker u_asseq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
